// ===== design/pvc_pkg.sv =====
package pvc_pkg;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam int JOB_BITS = 40;

    typedef struct packed {
        logic [31:0] value_in;
        logic [7:0]  byte_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [31:0] value_out;
        logic [2:0]  code_length;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic                decode;
        logic [2:0]          length;
        logic [JOB_BITS-1:0] data;
    } t_job;

endpackage

// ===== design/pvc_front.sv =====
module pvc_front import pvc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_valid,
    input  logic     i_cfg_data,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_job_valid,
    output t_job     o_job
);

    logic        r_dir;
    logic [2:0]  r_seen;
    logic [2:0]  r_need;
    logic [7:0]  r_lead;
    logic [31:0] r_acc;

    logic [2:0]  n_seen;
    logic [2:0]  n_need;
    logic [7:0]  n_lead;
    logic [31:0] n_acc;

    logic [31:0] w;
    logic [31:0] p;
    logic [2:0]  enc_len;
    logic [39:0] enc_data;

    logic [7:0]  b;
    logic [7:0]  hi;
    logic [31:0] base;
    logic [31:0] dec_word;
    logic        complete;

    always_comb begin
        w = i_item.value_in;
        p = ~w;
        if (w[31:29] == 3'd0) begin
            if (w[31:7] == 25'd0) begin
                enc_len  = 3'd1;
                enc_data = {w[7:0], 32'h0};
            end else if (w[31:13] == 19'd0) begin
                enc_len  = 3'd2;
                enc_data = {3'b100, w[12:0], 24'h0};
            end else if (w[31:21] == 11'd0) begin
                enc_len  = 3'd3;
                enc_data = {3'b101, w[20:0], 16'h0};
            end else begin
                enc_len  = 3'd4;
                enc_data = {3'b110, w[28:0], 8'h0};
            end
        end else begin
            if (p[31:11] == 21'd0) begin
                enc_len  = 3'd2;
                enc_data = {5'b11100, p[10:0], 24'h0};
            end else if (p[31:19] == 13'd0) begin
                enc_len  = 3'd3;
                enc_data = {5'b11101, p[18:0], 16'h0};
            end else if (p[31:27] == 5'd0) begin
                enc_len  = 3'd4;
                enc_data = {5'b11110, p[26:0], 8'h0};
            end else begin
                enc_len  = 3'd5;
                enc_data = {8'hf8, p};
            end
        end
    end

    always_comb begin
        b = i_item.byte_in;
        if (r_seen == 3'd0) begin
            n_lead = b;
            n_acc  = 32'h0;
            n_seen = 3'd1;
            if (!b[7]) begin
                n_need = 3'd1;
            end else begin
                unique case (b[6:5])
                    2'b00:   n_need = 3'd2;
                    2'b01:   n_need = 3'd3;
                    2'b10:   n_need = 3'd4;
                    default: n_need = {1'b0, b[4:3]} + 3'd2;
                endcase
            end
        end else begin
            n_lead = r_lead;
            n_acc  = {r_acc[23:0], b};
            n_seen = r_seen + 3'd1;
            n_need = r_need;
        end
        complete = (n_seen >= n_need);

        hi = (n_lead[6:5] == 2'b11) ? {5'd0, n_lead[2:0]} : {3'd0, n_lead[4:0]};
        unique case (n_need)
            3'd2:    base = {16'h0, hi, n_acc[7:0]};
            3'd3:    base = {8'h0, hi, n_acc[15:0]};
            3'd4:    base = {hi, n_acc[23:0]};
            default: base = 32'h0;
        endcase
        unique case (n_need)
            3'd1:    dec_word = {24'h0, n_lead};
            3'd5:    dec_word = ~n_acc;
            3'd2, 3'd3, 3'd4: begin
                dec_word = (n_lead[6:5] == 2'b11) ? ~base : base;
            end
            default: dec_word = {24'h0, n_lead};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= DIR_ENCODE;
            r_seen <= 3'd0;
            r_need <= 3'd0;
            r_lead <= 8'h0;
            r_acc  <= 32'h0;
        end else if (i_cfg_valid) begin
            r_dir  <= i_cfg_data;
            r_seen <= 3'd0;
            r_need <= 3'd0;
            r_lead <= 8'h0;
            r_acc  <= 32'h0;
        end else if (i_accept && r_dir == DIR_DECODE) begin
            if (complete) begin
                r_seen <= 3'd0;
                r_need <= 3'd0;
                r_lead <= 8'h0;
                r_acc  <= 32'h0;
            end else begin
                r_seen <= n_seen;
                r_need <= n_need;
                r_lead <= n_lead;
                r_acc  <= n_acc;
            end
        end
    end

    assign o_job_valid = i_accept && (r_dir == DIR_ENCODE || complete);

    always_comb begin
        if (r_dir == DIR_DECODE) begin
            o_job.decode = 1'b1;
            o_job.length = n_need;
            o_job.data   = {8'h0, dec_word};
        end else begin
            o_job.decode = 1'b0;
            o_job.length = enc_len;
            o_job.data   = enc_data;
        end
    end

endmodule

// ===== design/pvc_queue.sv =====
module pvc_queue import pvc_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== design/pvc_back.sv =====
module pvc_back import pvc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_job_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_out
);

    logic                r_busy;
    logic                r_dec;
    logic [2:0]          r_len;
    logic [2:0]          r_left;
    logic [JOB_BITS-1:0] r_cur;

    logic finish;
    logic load;

    assign finish    = r_busy && i_pop && (r_dec || r_left == 3'd1);
    assign load      = i_job_valid && (!r_busy || finish);
    assign o_job_pop = load;
    assign o_empty   = !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= 3'd0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_left <= i_job.length;
        end else if (finish) begin
            r_busy <= 1'b0;
        end else if (r_busy && i_pop) begin
            r_left <= r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_dec <= i_job.decode;
            r_len <= i_job.length;
            r_cur <= i_job.data;
        end else if (r_busy && i_pop) begin
            r_cur <= {r_cur[JOB_BITS-9:0], 8'h0};
        end
    end

    always_comb begin
        o_out.byte_out    = r_dec ? 8'h0 : r_cur[JOB_BITS-1 -: 8];
        o_out.value_out   = r_dec ? r_cur[31:0] : 32'h0;
        o_out.code_length = r_len;
        o_out.last        = r_dec || (r_left == 3'd1);
    end

endmodule

// ===== design/prefix_varint_codec.sv =====
// A job is registered in the queue at the accepting edge, then loaded into the byte serializer that shows the result.
// Throughput: one beat per cycle on each side while the queue is not full and results are popped;
// the byte serializer sends an encoded word one code byte per pop.
// Decoding takes one byte per cycle while the queue is not full; a word is queued with the final byte of its run.
// Reset: synchronous, active low; clears direction to encode, decode state, the job queue and the serializer.
module prefix_varint_codec import pvc_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data,
    input  logic      i_push,
    output logic      o_full,
    input  t_in_item  i_in,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_out
);

    logic accept;
    logic cfg_write;
    logic job_valid;
    t_job job_in;
    logic q_empty;
    logic q_pop;
    t_job job_out;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign accept      = i_push && !o_full;

    pvc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_write),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_item      (i_in),
        .o_job_valid (job_valid),
        .o_job       (job_in)
    );

    pvc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_data  (job_in),
        .o_full  (o_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (job_out)
    );

    pvc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .i_job       (job_out),
        .o_job_pop   (q_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_out       (o_out)
    );

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_out.code_length >= 3'd1 && o_out.code_length <= 3'd5))
        else $error("result code length out of range");

    a_mid_run_encode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_out.last) |-> (o_out.value_out == 32'h0 && o_out.code_length >= 3'd2))
        else $error("non-final beat not part of an encoded run");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && !o_out.last) |=> (!o_empty && $stable(o_out.code_length)))
        else $error("encoded run broken before its final byte");

endmodule

// ===== tb/sv/prefix_varint_codec_tb.sv =====
module prefix_varint_codec_tb import pvc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS = 52;

    class varint_ledger;
        logic        dir;
        logic [2:0]  seen;
        logic [2:0]  need;
        logic [7:0]  lead;
        logic [31:0] acc;
        t_out_item   awaited[$];
        int unsigned mismatches;

        function new();
            dir = DIR_ENCODE;
            mismatches = 0;
            clear_run();
        endfunction

        function void clear_run();
            seen = '0;
            need = '0;
            lead = '0;
            acc  = '0;
        endfunction

        function void set_direction(logic d);
            dir = d;
            clear_run();
        endfunction

        function void code_bytes(logic [31:0] n, output logic [7:0] q[$]);
            logic [31:0] p;
            int          len;
            logic [7:0]  head;
            q.delete();
            if (n <= 32'h1fffffff) begin
                p = n;
                if (n <= 32'h7f) begin
                    len = 1; head = 8'h00;
                end else if (n <= 32'h1fff) begin
                    len = 2; head = 8'h80;
                end else if (n <= 32'h1fffff) begin
                    len = 3; head = 8'ha0;
                end else begin
                    len = 4; head = 8'hc0;
                end
            end else begin
                p = ~n;
                if (p <= 32'h7ff) begin
                    len = 2; head = 8'he0;
                end else if (p <= 32'h7ffff) begin
                    len = 3; head = 8'he8;
                end else if (p <= 32'h7ffffff) begin
                    len = 4; head = 8'hf0;
                end else begin
                    len = 5; head = 8'hf8;
                end
            end
            for (int k = 0; k < len; k++) begin
                if (k == 0) begin
                    q.push_back((len == 5) ? head : (head | 8'(p >> (8 * (len - 1)))));
                end else begin
                    q.push_back(8'(p >> (8 * (len - 1 - k))));
                end
            end
        endfunction

        function logic [2:0] lead_length(logic [7:0] b);
            if (!b[7]) return 3'd1;
            case (b[6:5])
                2'b00: return 3'd2;
                2'b01: return 3'd3;
                2'b10: return 3'd4;
                default: return 3'(b[4:3]) + 3'd2;
            endcase
        endfunction

        function logic [31:0] decoded_word();
            int sh;
            if (need <= 3'd1) return {24'b0, lead};
            if (need >= 3'd5) return ~acc;
            sh = 8 * (need - 1);
            if (lead[6:5] == 2'b11) return ~((32'(lead[2:0]) << sh) | acc);
            return (32'(lead[4:0]) << sh) | acc;
        endfunction

        function void note_item(t_in_item it);
            logic [7:0] q[$];
            t_out_item  e;
            if (dir == DIR_ENCODE) begin
                code_bytes(it.value_in, q);
                foreach (q[k]) begin
                    e.byte_out    = q[k];
                    e.value_out   = '0;
                    e.code_length = 3'(q.size());
                    e.last        = (k == q.size() - 1);
                    awaited.push_back(e);
                end
            end else begin
                if (seen == 3'd0) begin
                    lead = it.byte_in;
                    need = lead_length(it.byte_in);
                    acc  = '0;
                    seen = 3'd1;
                end else begin
                    acc  = {acc[23:0], it.byte_in};
                    seen = seen + 3'd1;
                end
                if (seen >= need) begin
                    e.byte_out    = '0;
                    e.value_out   = decoded_word();
                    e.code_length = need;
                    e.last        = 1'b1;
                    awaited.push_back(e);
                    clear_run();
                end
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: byte %h word %h len %0d last %b",
                             got.byte_out, got.value_out, got.code_length, got.last);
                return;
            end
            e = awaited.pop_front();
            if (got.byte_out !== e.byte_out || got.value_out !== e.value_out ||
                got.code_length !== e.code_length || got.last !== e.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: exp byte %h word %h len %0d last %b",
                             e.byte_out, e.value_out, e.code_length, e.last);
                    $display("          got byte %h word %h len %0d last %b",
                             got.byte_out, got.value_out, got.code_length, got.last);
                end
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic      i_cfg_data;
    logic      i_push;
    logic      o_full;
    t_in_item  i_in;
    logic      o_empty;
    logic      i_pop;
    t_out_item o_out;

    bit quiet;
    bit hold_rx;
    int stalled = 0;
    varint_ledger book;

    prefix_varint_codec uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_in        (i_in),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_out       (o_out)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    initial begin
        i_pop = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            i_pop <= !hold_rx && (quiet || $urandom_range(99) >= 36);
            @(posedge i_clk);
            if (i_pop && !o_empty) book.check_result(o_out);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_push && !o_full) || (i_pop && !o_empty) || (i_cfg_valid && o_cfg_ready))
                stalled <= 0;
            else
                stalled <= stalled + 1;
            if (stalled >= STALL_LIMIT) begin
                $display("** prefix_varint_codec: FAILED **");
                $finish;
            end
        end
    end

    task automatic drive_item(t_in_item it);
        while (!quiet && $urandom_range(99) < 36) begin
            i_push <= 1'b0;
            @(negedge i_clk);
        end
        i_push <= 1'b1;
        i_in   <= it;
        do @(posedge i_clk); while (o_full);
        book.note_item(it);
        @(negedge i_clk);
    endtask

    task automatic send_word(logic [31:0] w);
        t_in_item it;
        it.value_in = w;
        it.byte_in  = 8'($urandom);
        drive_item(it);
    endtask

    task automatic send_byte(logic [7:0] b);
        t_in_item it;
        it.value_in = $urandom;
        it.byte_in  = b;
        drive_item(it);
    endtask

    task automatic write_direction(logic d);
        i_push <= 1'b0;
        while (book.awaited.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        book.set_direction(d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(8))
            0: return $urandom_range(32'h7f, 0);
            1: return $urandom_range(32'h1fff, 32'h80);
            2: return $urandom_range(32'h1fffff, 32'h2000);
            3: return $urandom_range(32'h1fffffff, 32'h200000);
            4: return ~$urandom_range(32'h7ff, 0);
            5: return ~$urandom_range(32'h7ffff, 32'h800);
            6: return ~$urandom_range(32'h7ffffff, 32'h80000);
            7: return ~$urandom_range(32'hdfffffff, 32'h8000000);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_words(int n);
        for (int k = 0; k < n; k++) send_word(pick_word());
    endtask

    task automatic random_bytes(int n);
        int         count;
        int         r;
        int         keep;
        logic [7:0] q[$];
        count = 0;
        while (count < n) begin
            r = $urandom_range(99);
            if (r < 20) begin
                send_byte(8'($urandom));
                count++;
            end else begin
                book.code_bytes(pick_word(), q);
                if (q.size() == 5) q[0][2:0] = 3'($urandom);
                keep = q.size();
                if (r < 28 && keep > 1) keep = $urandom_range(keep - 1, 1);
                for (int k = 0; k < keep; k++) send_byte(q[k]);
                count += keep;
            end
        end
    endtask

    logic [31:0] edge_words[] = '{32'h0, 32'h7f, 32'h80, 32'h1fffff, 32'h200000,
                                  32'h1fffffff, 32'h20000000, 32'hfffff800, 32'hfffff7ff,
                                  32'hf8000000, 32'hf7ffffff, 32'hffffffff};
    logic [7:0]  edge_bytes[] = '{8'h7f, 8'h9f, 8'hff, 8'he7, 8'hff,
                                  8'hff, 8'h12, 8'h34, 8'h56, 8'h78, 8'hc0, 8'h12};

    initial begin
        book        = new();
        quiet       = 1'b0;
        hold_rx     = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 1'b0;
        i_push      = 1'b0;
        i_in        = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (edge_words[k]) send_word(edge_words[k]);
        write_direction(DIR_DECODE);
        foreach (edge_bytes[k]) send_byte(edge_bytes[k]);
        // drop the partial run left in the decoder
        write_direction(DIR_DECODE);

        for (int ph = 0; ph < 4; ph++) begin
            write_direction((ph % 2) ? DIR_DECODE : DIR_ENCODE);
            quiet = (ph == 2);
            if (ph == 0) begin
                fork
                    begin
                        repeat (20) @(posedge i_clk);
                        hold_rx = 1'b1;
                        repeat (120) @(posedge i_clk);
                        hold_rx = 1'b0;
                    end
                join_none
            end
            if (ph % 2) random_bytes(PHASE_ITEMS);
            else random_words(PHASE_ITEMS);
        end
        quiet  = 1'b0;
        i_push <= 1'b0;

        while (book.awaited.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (book.mismatches == 0 && book.awaited.size() == 0) begin
            $display("** prefix_varint_codec: PASSED **");
        end else begin
            $display("** prefix_varint_codec: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/pvc_pkg.sv
design/pvc_front.sv
design/pvc_queue.sv
design/pvc_back.sv
design/prefix_varint_codec.sv
tb/sv/prefix_varint_codec_tb.sv
